// ----- hdl/frs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frs_pkg
// Shared constants and helpers of the fast reciprocal square root pipeline.
// ----------------------------------------------------------------------------
package frs_pkg;

   localparam int unsigned OP_LAT           = 3;  // stages of one float unit
   localparam int unsigned REFINE_STEPS_DEF = 3;

   localparam logic [31:0] MAGIC_GUESS = 32'h5f3759df;
   localparam logic [31:0] CANON_NAN   = 32'h7fc00000;
   localparam logic [31:0] FP_ONE_HALF = 32'h3fc00000;  // 1.5
   localparam logic [31:0] FP_HALF     = 32'h3f000000;  // 0.5

   function automatic logic [31:0] canon_nan(input logic [31:0] b);
      if (b[30:23] == 8'hff && b[22:0] != 23'd0) begin
         return CANON_NAN;
      end
      return b;
   endfunction

   // position of the leading one, zero word gives 0
   function automatic logic [5:0] lead_one48(input logic [47:0] v);
      logic [5:0] pos;
      pos = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) begin
            pos = 6'(i);
         end
      end
      return pos;
   endfunction

   // leading zeros of a 27-bit word, zero word gives 27
   function automatic logic [4:0] lead_zeros27(input logic [26:0] v);
      logic [4:0] cnt;
      cnt = 5'd27;
      for (int i = 0; i < 27; i++) begin
         if (v[i]) begin
            cnt = 5'(26 - i);
         end
      end
      return cnt;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/frs_fmul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frs_fmul
// Binary32 multiplier, round to nearest even, subnormals kept, three stages.
// ----------------------------------------------------------------------------
module frs_fmul
   import frs_pkg::*;
(
   input  wire         clock,
   input  wire         en,
   input  wire  [31:0] a,
   input  wire  [31:0] b,
   output logic [31:0] p
);

   logic        sign_s1_ff, nan_s1_ff, inf_s1_ff, zero_s1_ff;
   logic [9:0]  esum_s1_ff;
   logic [47:0] prod_s1_ff;

   logic        sign_s2_ff, nan_s2_ff, inf_s2_ff, zero_s2_ff;
   logic signed [10:0] e_s2_ff;
   logic [47:0] q_s2_ff;

   logic [31:0] p_ff;

   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [7:0]  ea_eff, eb_eff;
   logic [23:0] ma, mb;
   logic [5:0]  lead;
   logic signed [10:0] e_s2_in;
   logic [47:0] q_s2_in;
   logic signed [10:0] rsh_full;
   logic [5:0]  rsh;
   logic [95:0] wide;
   logic [23:0] sig;
   logic        grd, stk, inc, normal;
   logic [30:0] rounded;
   logic [31:0] p_in;

   always_comb begin
      a_nan  = a[30:23] == 8'hff && a[22:0] != 23'd0;
      b_nan  = b[30:23] == 8'hff && b[22:0] != 23'd0;
      a_inf  = a[30:23] == 8'hff && a[22:0] == 23'd0;
      b_inf  = b[30:23] == 8'hff && b[22:0] == 23'd0;
      a_zero = a[30:0] == 31'd0;
      b_zero = b[30:0] == 31'd0;
      ea_eff = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb_eff = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma     = {a[30:23] != 8'd0, a[22:0]};
      mb     = {b[30:23] != 8'd0, b[22:0]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sign_s1_ff <= a[31] ^ b[31];
         nan_s1_ff  <= a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
         inf_s1_ff  <= a_inf || b_inf;
         zero_s1_ff <= a_zero || b_zero;
         esum_s1_ff <= {2'b00, ea_eff} + {2'b00, eb_eff};
         prod_s1_ff <= ma * mb;
      end
   end

   // normalize so that the leading one sits at bit 47
   always_comb begin
      lead    = lead_one48(prod_s1_ff);
      e_s2_in = $signed({5'd0, lead}) + $signed({1'b0, esum_s1_ff}) - 11'sd173;
      q_s2_in = prod_s1_ff << (6'd47 - lead);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sign_s2_ff <= sign_s1_ff;
         nan_s2_ff  <= nan_s1_ff;
         inf_s2_ff  <= inf_s1_ff;
         zero_s2_ff <= zero_s1_ff;
         e_s2_ff    <= e_s2_in;
         q_s2_ff    <= q_s2_in;
      end
   end

   // subnormal results shift right, lost bits fold into sticky
   always_comb begin
      normal   = e_s2_ff > 11'sd0;
      rsh_full = 11'sd1 - e_s2_ff;
      if (normal) begin
         rsh = 6'd0;
      end else if (rsh_full > 11'sd48) begin
         rsh = 6'd48;
      end else begin
         rsh = rsh_full[5:0];
      end
      wide    = {q_s2_ff, 48'd0} >> rsh;
      sig     = wide[95:72];
      grd     = wide[71];
      stk     = (wide[70:48] != 23'd0) || (wide[47:0] != 48'd0);
      inc     = grd && (stk || sig[0]);
      rounded = {(normal ? e_s2_ff[7:0] : 8'd0), sig[22:0]} + {30'd0, inc};
      if (nan_s2_ff) begin
         p_in = CANON_NAN;
      end else if (inf_s2_ff) begin
         p_in = {sign_s2_ff, 8'hff, 23'd0};
      end else if (zero_s2_ff) begin
         p_in = {sign_s2_ff, 31'd0};
      end else if (e_s2_ff >= 11'sd255) begin
         p_in = {sign_s2_ff, 8'hff, 23'd0};
      end else begin
         p_in = {sign_s2_ff, rounded};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule
`default_nettype wire

// ----- hdl/frs_fsub.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frs_fsub
// Binary32 subtractor a - b, round to nearest even, subnormals kept, three
// stages.
// ----------------------------------------------------------------------------
module frs_fsub
   import frs_pkg::*;
(
   input  wire         clock,
   input  wire         en,
   input  wire  [31:0] a,
   input  wire  [31:0] b,
   output logic [31:0] d
);

   logic        sign_s1_ff, nan_s1_ff, inf_s1_ff, infsign_s1_ff, zsign_s1_ff;
   logic [7:0]  e_s1_ff;
   logic [27:0] s_s1_ff;

   logic        sign_s2_ff, nan_s2_ff, inf_s2_ff, infsign_s2_ff, zsign_s2_ff, zero_s2_ff;
   logic [8:0]  e_s2_ff;
   logic [26:0] n_s2_ff;

   logic [31:0] d_ff;

   logic [31:0] nb, big, sml;
   logic        a_nan, b_nan, a_inf, b_inf;
   logic [7:0]  e_big, e_sml, exp_gap;
   logic [4:0]  exp_gap_c;
   logic [26:0] sig_a, sig_b;
   logic [53:0] align;
   logic [26:0] sig_bs;
   logic [27:0] s_in;
   logic [4:0]  lz;
   logic [7:0]  sh;
   logic [8:0]  e_s2_in;
   logic [26:0] n_s2_in;
   logic [23:0] sig;
   logic        grd, stk, inc;
   logic [30:0] rounded;
   logic [31:0] d_in;

   always_comb begin
      nb     = {~b[31], b[30:0]};
      a_nan  = a[30:23] == 8'hff && a[22:0] != 23'd0;
      b_nan  = b[30:23] == 8'hff && b[22:0] != 23'd0;
      a_inf  = a[30:23] == 8'hff && a[22:0] == 23'd0;
      b_inf  = b[30:23] == 8'hff && b[22:0] == 23'd0;
      if (a[30:0] >= nb[30:0]) begin
         big = a;
         sml = nb;
      end else begin
         big = nb;
         sml = a;
      end
      e_big  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      e_sml  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      exp_gap   = e_big - e_sml;
      exp_gap_c = (exp_gap > 8'd27) ? 5'd27 : exp_gap[4:0];
      sig_a  = {big[30:23] != 8'd0, big[22:0], 3'b000};
      sig_b  = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
      align  = {sig_b, 27'd0} >> exp_gap_c;
      sig_bs = {align[53:28], align[27] || (align[26:0] != 27'd0)};
      if (big[31] ^ sml[31]) begin
         s_in = {1'b0, sig_a} - {1'b0, sig_bs};
      end else begin
         s_in = {1'b0, sig_a} + {1'b0, sig_bs};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sign_s1_ff    <= big[31];
         nan_s1_ff     <= a_nan || b_nan || (a_inf && b_inf && (a[31] != nb[31]));
         inf_s1_ff     <= a_inf || b_inf;
         infsign_s1_ff <= a_inf ? a[31] : nb[31];
         zsign_s1_ff   <= a[31] && nb[31];
         e_s1_ff       <= e_big;
         s_s1_ff       <= s_in;
      end
   end

   // normalize, left shifts stop at the subnormal exponent
   always_comb begin
      lz = lead_zeros27(s_s1_ff[26:0]);
      if (s_s1_ff[27]) begin
         sh      = 8'd0;
         e_s2_in = {1'b0, e_s1_ff} + 9'd1;
         n_s2_in = {s_s1_ff[27:2], s_s1_ff[1] || s_s1_ff[0]};
      end else begin
         sh      = ({3'd0, lz} < e_s1_ff - 8'd1) ? {3'd0, lz} : e_s1_ff - 8'd1;
         e_s2_in = {1'b0, e_s1_ff - sh};
         n_s2_in = s_s1_ff[26:0] << sh;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sign_s2_ff    <= sign_s1_ff;
         nan_s2_ff     <= nan_s1_ff;
         inf_s2_ff     <= inf_s1_ff;
         infsign_s2_ff <= infsign_s1_ff;
         zsign_s2_ff   <= zsign_s1_ff;
         zero_s2_ff    <= s_s1_ff == 28'd0;
         e_s2_ff       <= e_s2_in;
         n_s2_ff       <= n_s2_in;
      end
   end

   always_comb begin
      sig     = n_s2_ff[26:3];
      grd     = n_s2_ff[2];
      stk     = n_s2_ff[1] || n_s2_ff[0];
      inc     = grd && (stk || sig[0]);
      rounded = {(n_s2_ff[26] ? e_s2_ff[7:0] : 8'd0), sig[22:0]} + {30'd0, inc};
      if (nan_s2_ff) begin
         d_in = CANON_NAN;
      end else if (inf_s2_ff) begin
         d_in = {infsign_s2_ff, 8'hff, 23'd0};
      end else if (zero_s2_ff) begin
         d_in = {zsign_s2_ff, 31'd0};
      end else if (e_s2_ff >= 9'd255) begin
         d_in = {sign_s2_ff, 8'hff, 23'd0};
      end else begin
         d_in = {sign_s2_ff, rounded};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in;
      end
   end

   assign d = d_ff;

endmodule
`default_nettype wire

// ----- hdl/frs_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frs_cell
// One Newton step y * (1.5 - (xhalf * y) * y), pipelined over four float
// units; passes xhalf and the new y to the next cell.
// ----------------------------------------------------------------------------
module frs_cell
   import frs_pkg::*;
(
   input  wire         clock,
   input  wire         en,
   input  wire  [31:0] xhalf_in,
   input  wire  [31:0] y_in,
   output logic [31:0] xhalf_out,
   output logic [31:0] y_out
);

   localparam int unsigned YDEPTH = 3 * OP_LAT;
   localparam int unsigned XDEPTH = 4 * OP_LAT;

   logic [31:0] ydly_ff [YDEPTH];
   logic [31:0] xdly_ff [XDEPTH];
   logic [31:0] t1, t2, t3;

   always_ff @(posedge clock) begin
      if (en) begin
         ydly_ff[0] <= y_in;
         xdly_ff[0] <= xhalf_in;
         for (int i = 1; i < YDEPTH; i++) begin
            ydly_ff[i] <= ydly_ff[i-1];
         end
         for (int i = 1; i < XDEPTH; i++) begin
            xdly_ff[i] <= xdly_ff[i-1];
         end
      end
   end

   frs_fmul u_mul_xy (
      .clock (clock), .en (en), .a (xhalf_in), .b (y_in), .p (t1)
   );

   frs_fmul u_mul_yy (
      .clock (clock), .en (en), .a (t1), .b (ydly_ff[OP_LAT-1]), .p (t2)
   );

   frs_fsub u_sub (
      .clock (clock), .en (en), .a (FP_ONE_HALF), .b (t2), .d (t3)
   );

   frs_fmul u_mul_out (
      .clock (clock), .en (en), .a (ydly_ff[YDEPTH-1]), .b (t3), .p (y_out)
   );

   assign xhalf_out = xdly_ff[XDEPTH-1];

endmodule
`default_nettype wire

// ----- hdl/fast_inverse_sqrt_single.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fast_inverse_sqrt_single
// Approximate 1/sqrt(x) on binary32: magic-constant guess, then a row of
// Newton step cells.
// ----------------------------------------------------------------------------
//   channel  ports                           direction
//   req      req_valid/ready, req_operand_bits   in
//   rsp      rsp_valid/ready, rsp_recip_root_bits out
//
// one item per cycle while the pipeline advances; the depth is set by the
// three-stage float units, four of them per Newton cell plus the 0.5 * x unit
// the whole pipeline advances together; it stalls only while the result at
// the end waits and rsp_ready is low
// reset clears the valid bits of every stage
module fast_inverse_sqrt_single
   import frs_pkg::*;
#(
   parameter int unsigned REFINE_STEPS = REFINE_STEPS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [31:0] req_operand_bits,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [31:0] rsp_recip_root_bits
);

   localparam int unsigned DEPTH = OP_LAT * (1 + 4 * REFINE_STEPS);

   logic             advance;
   logic [DEPTH-1:0] vld_ff, vld_in;
   logic [31:0]      guess;
   logic [31:0]      gdly_ff [OP_LAT];
   logic [31:0]      xh_chain [REFINE_STEPS+1];
   logic [31:0]      y_chain  [REFINE_STEPS+1];

   assign advance   = !vld_ff[DEPTH-1] || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      vld_in = {vld_ff[DEPTH-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   assign guess = MAGIC_GUESS - {req_operand_bits[31], req_operand_bits[31:1]};

   // guess waits for 0.5 * x
   always_ff @(posedge clock) begin
      if (advance) begin
         gdly_ff[0] <= guess;
         for (int i = 1; i < OP_LAT; i++) begin
            gdly_ff[i] <= gdly_ff[i-1];
         end
      end
   end

   frs_fmul u_half (
      .clock (clock), .en (advance), .a (req_operand_bits), .b (FP_HALF),
      .p (xh_chain[0])
   );

   assign y_chain[0] = gdly_ff[OP_LAT-1];

   for (genvar k = 0; k < REFINE_STEPS; k++) begin : g_cell
      frs_cell u_cell (
         .clock     (clock),
         .en        (advance),
         .xhalf_in  (xh_chain[k]),
         .y_in      (y_chain[k]),
         .xhalf_out (xh_chain[k+1]),
         .y_out     (y_chain[k+1])
      );
   end

   assign rsp_valid           = vld_ff[DEPTH-1];
   assign rsp_recip_root_bits = canon_nan(y_chain[REFINE_STEPS]);

endmodule
`default_nettype wire

// ----- hdl/frs_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// frs_checker
// Port-level checks of the reciprocal square root block.
// ----------------------------------------------------------------------------
module frs_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire [31:0] req_operand_bits,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [31:0] rsp_recip_root_bits
);

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_recip_root_bits))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // input is taken whenever the end of the pipe is free
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("ready does not follow the output side");

   a_nan_canon: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_recip_root_bits[30:23] == 8'hff && rsp_recip_root_bits[22:0] != 23'd0
      |-> rsp_recip_root_bits == 32'h7fc00000)
      else $error("nan item not canonical");

endmodule

bind fast_inverse_sqrt_single frs_checker u_frs_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .req_operand_bits    (req_operand_bits),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_recip_root_bits (rsp_recip_root_bits)
);
`default_nettype wire

// ----- tb/sv/frs_checker.sv -----
// ----------------------------------------------------------------------------
// frs_scoreboard
// Watches both channels of the reciprocal square root block. It works out the
// expected binary32 result of every accepted operand and compares it with the
// results in order.
// ----------------------------------------------------------------------------
module frs_scoreboard
   import frs_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_ready,
   input  wire  [31:0] req_operand_bits,
   input  wire         rsp_valid,
   input  wire         rsp_ready,
   input  wire  [31:0] rsp_recip_root_bits,
   output int          fail_count,
   output int          pending
);

   logic [31:0] expected_roots[$];

   // widen a binary32 pattern to a real without loss, subnormals included
   function automatic real sp_to_real(input logic [31:0] b);
      logic [63:0] d;
      logic [63:0] m;
      int p;
      d = {b[31], 63'd0};
      p = 0;
      if (b[30:23] == 8'hff) begin
         d[62:0] = {11'h7ff, b[22:0], 29'd0};
      end else if (b[30:23] != 8'd0) begin
         d[62:0] = {11'(int'(b[30:23]) + 896), b[22:0], 29'd0};
      end else if (b[22:0] != 23'd0) begin
         for (int i = 0; i < 23; i++) begin
            if (b[i]) begin
               p = i;
            end
         end
         m = 64'(b[22:0]) << (52 - p);
         d[62:52] = 11'(p - 149 + 1023);
         d[51:0] = m[51:0];
      end
      return $bitstoreal(d);
   endfunction

   // round a real to binary32, nearest even, with gradual underflow
   function automatic logic [31:0] real_to_sp(input real r);
      logic [63:0] d;
      logic [63:0] m;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      logic        s;
      int e;
      int sh;
      d = $realtobits(r);
      s = d[63];
      if (d[62:52] == 11'h7ff) begin
         if (d[51:0] != 52'd0) begin
            return CANON_NAN;
         end
         return {s, 8'hff, 23'd0};
      end
      if (d[62:52] == 11'd0) begin
         return {s, 31'd0};
      end
      e = int'(d[62:52]) - 1023;
      if (e > 127) begin
         return {s, 8'hff, 23'd0};
      end
      m = {11'd0, 1'b1, d[51:0]};
      sh = (e >= -126) ? 29 : 29 + (-126 - e);
      if (sh > 60) begin
         return {s, 31'd0};
      end
      q = m >> sh;
      rem = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) begin
         q = q + 64'd1;
      end
      if (e >= -126) begin
         if (q[24]) begin
            q = q >> 1;
            e = e + 1;
         end
         if (e > 127) begin
            return {s, 8'hff, 23'd0};
         end
         return {s, 8'(e + 127), q[22:0]};
      end
      // a carry out of the subnormal range lands on the smallest normal
      return {s, q[30:0]};
   endfunction

   function automatic logic [31:0] recip_root_predict(input logic [31:0] x_bits);
      logic [31:0] half_shift;
      logic [31:0] y;
      logic [31:0] x_half;
      logic [31:0] t;
      half_shift = {x_bits[31], x_bits[31:1]};
      y = MAGIC_GUESS - half_shift;
      x_half = real_to_sp(0.5 * sp_to_real(x_bits));
      for (int k = 0; k < REFINE_STEPS_DEF; k++) begin
         t = real_to_sp(sp_to_real(x_half) * sp_to_real(y));
         t = real_to_sp(sp_to_real(t) * sp_to_real(y));
         t = real_to_sp(1.5 - sp_to_real(t));
         y = real_to_sp(sp_to_real(y) * sp_to_real(t));
      end
      return canon_nan(y);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_roots.push_back(recip_root_predict(req_operand_bits));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_roots.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_recip_root_bits);
               fail_count <= fail_count + 1;
            end else begin
               if (expected_roots[0] !== rsp_recip_root_bits) begin
                  $display("%0t: recip_root_bits expected %h actual %h", $time,
                           expected_roots[0], rsp_recip_root_bits);
                  fail_count <= fail_count + 1;
               end
               void'(expected_roots.pop_front());
            end
         end
      end
      pending <= expected_roots.size();
   end

endmodule

// ----- tb/sv/tb_fast_inverse_sqrt_single.sv -----
// ----------------------------------------------------------------------------
// tb_fast_inverse_sqrt_single
// Feeds binary32 operands to the reciprocal square root block: special values
// first, then random patterns with random gaps and result stalls. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_fast_inverse_sqrt_single;

   localparam int DRAIN_CYCLES = 60;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 1100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_operand_bits = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_recip_root_bits;
   int          fail_count;
   int          pending;
   int          sent = 0;
   int          received = 0;
   int          idle_cycles = 0;
   int          stall_left = 0;
   bit          sender_burst = 1'b0;
   bit          receiver_burst = 1'b0;

   always #5 clock = ~clock;

   fast_inverse_sqrt_single dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_operand_bits(req_operand_bits),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_recip_root_bits(rsp_recip_root_bits)
   );

   frs_scoreboard checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_operand_bits(req_operand_bits),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_recip_root_bits(rsp_recip_root_bits),
      .fail_count(fail_count), .pending(pending)
   );

   // receiver: a random stall before each item, with stretches of none
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         received <= received + 1;
         if (($urandom_range(0, 99)) == 0) begin
            receiver_burst <= ~receiver_burst;
         end
         stall_left <= receiver_burst ? 0 : $urandom_range(0, 11);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // valid stays high across back-to-back items, dropped only for a gap
   task automatic send_operand(input logic [31:0] x_bits);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operand_bits <= x_bits;
      do @(posedge clock); while (!req_ready);
      sent++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_operand();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 7))
         0: v[30:23] = 8'h00;
         1: v[30:23] = 8'hff;
         2: v[30:23] = 8'(8'd120 + $urandom_range(0, 15));
         3: v[30:0] = 31'($urandom_range(0, 3));
         default: ;
      endcase
      return v;
   endfunction

   initial begin
      logic [31:0] directed_ops[$];
      directed_ops = '{32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000,
                       32'h7fc00000, 32'hffc00000, 32'h7f800001, 32'hffffffff,
                       32'h00000001, 32'h007fffff, 32'h807fffff, 32'h00800000,
                       32'h3f800000, 32'h40800000, 32'h3e800000, 32'h7f7fffff,
                       32'hbf800000, 32'hc0000000, 32'h5f3759df, 32'hbe6eb3be,
                       32'h55555555, 32'haaaaaaaa, 32'h3f7fffff, 32'h01000000};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_ops[i]) begin
         send_operand(directed_ops[i]);
      end
      // let the pipeline drain completely before random traffic
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ((n % 50) == 0) begin
            sender_burst = ($urandom_range(0, 3) == 0);
         end
         send_operand(random_operand());
      end
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d operands: signed zeros, infinities, nans, subnormals,", sent);
      $display("negative inputs and random patterns; %0d results checked", received);
      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- fast_inverse_sqrt_single.f -----
hdl/frs_pkg.sv
hdl/frs_fmul.sv
hdl/frs_fsub.sv
hdl/frs_cell.sv
hdl/fast_inverse_sqrt_single.sv
hdl/frs_checker.sv
tb/sv/frs_checker.sv
tb/sv/tb_fast_inverse_sqrt_single.sv
